/* design/frm_pkg.sv */
package frm_pkg;

  typedef enum logic [2:0] {
    MODE_GRAY      = 3'd0,
    MODE_NEGATIVE  = 3'd1,
    MODE_FLIP      = 3'd2,
    MODE_ROT_RIGHT = 3'd3,
    MODE_ROT_LEFT  = 3'd4,
    MODE_COPY      = 3'd5,
    MODE_VMIRROR   = 3'd6,
    MODE_HMIRROR   = 3'd7
  } mode_t;

  typedef struct packed {
    logic  vld;
    logic  load;
    logic  last;
    mode_t mode;
  } ctl_t;

  localparam logic       FUNC_LOAD = 1'b0;
  localparam logic       FUNC_EMIT = 1'b1;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam int         CFG_DW = 9;
  localparam logic [8:0] DIM_RESET = 9'd256;

  localparam logic [16:0] GRAY_R_COEF = 17'd19595;
  localparam logic [16:0] GRAY_G_COEF = 17'd38470;
  localparam logic [16:0] GRAY_B_COEF = 17'd7471;
  localparam logic [7:0]  PIX_MAX     = 8'd255;

endpackage

/* design/frm_ram.sv */
module frm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                  clk,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic                                  we,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* design/frm_scan.sv */
module frm_scan #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int CW         = 9,
  parameter int AW         = 16,
  parameter int LCW        = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                acc,
  input  logic                func,
  input  logic [23:0]         pix,
  input  frm_pkg::mode_t      mode,
  input  logic [8:0]          fw,
  input  logic [8:0]          fh,
  output frm_pkg::ctl_t       ctl_a,
  output logic [CW-1:0]       sr_a,
  output logic [CW-1:0]       sc_a,
  output logic [AW-1:0]       wa_a,
  output logic [23:0]         pix_a,
  output logic [CW-1:0]       w_eff
);

  localparam int EW = (CW > frm_pkg::CFG_DW) ? CW : frm_pkg::CFG_DW;
  localparam int LW = 2 * CW;

  logic [CW-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [LCW-1:0] lc_r, lc_nxt, lc_base;
  frm_pkg::ctl_t  ctl_r;
  logic [CW-1:0]  sr_r, sc_r;
  logic [AW-1:0]  wa_r;
  logic [23:0]    pix_r;

  logic [CW-1:0]  wv, hv, ow, oh, r0, c0, sr, sc;
  logic [LW-1:0]  area;
  logic           rot, oob, col_end, row_end, newf, last;

  always_comb begin
    if (fw == '0) begin
      wv = CW'(1);
    end else if (EW'(fw) > EW'(MAX_WIDTH)) begin
      wv = CW'(MAX_WIDTH);
    end else begin
      wv = CW'(fw);
    end
    if (fh == '0) begin
      hv = CW'(1);
    end else if (EW'(fh) > EW'(MAX_HEIGHT)) begin
      hv = CW'(MAX_HEIGHT);
    end else begin
      hv = CW'(fh);
    end
  end

  assign area = LW'(wv) * LW'(hv);
  assign rot  = (mode == frm_pkg::MODE_ROT_RIGHT) || (mode == frm_pkg::MODE_ROT_LEFT);
  assign ow   = rot ? hv : wv;
  assign oh   = rot ? wv : hv;
  assign oob  = (row_r >= oh) || (col_r >= ow);
  assign r0   = oob ? '0 : row_r;
  assign c0   = oob ? '0 : col_r;

  always_comb begin
    sr = r0;
    sc = c0;
    unique case (mode)
      frm_pkg::MODE_FLIP: begin
        sr = hv - CW'(1) - r0;
        sc = wv - CW'(1) - c0;
      end
      frm_pkg::MODE_ROT_RIGHT: begin
        sr = hv - CW'(1) - c0;
        sc = r0;
      end
      frm_pkg::MODE_ROT_LEFT: begin
        sr = c0;
        sc = wv - CW'(1) - r0;
      end
      frm_pkg::MODE_VMIRROR: begin
        if (c0 >= (wv >> 1)) sc = wv - CW'(1) - c0;
      end
      frm_pkg::MODE_HMIRROR: begin
        if (r0 >= (hv >> 1)) sr = hv - CW'(1) - r0;
      end
      default: begin
      end
    endcase
  end

  assign col_end = ({1'b0, c0} + (CW+1)'(1)) >= {1'b0, ow};
  assign row_end = ({1'b0, r0} + (CW+1)'(1)) >= {1'b0, oh};
  assign last    = col_end && row_end;

  assign newf    = LW'(lc_r) >= area;
  assign lc_base = newf ? '0 : lc_r;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    lc_nxt  = lc_r;
    if (acc) begin
      if (func == frm_pkg::FUNC_LOAD) begin
        lc_nxt = lc_base + LCW'(1);
        if (newf) begin
          row_nxt = '0;
          col_nxt = '0;
        end
      end else begin
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_end ? '0 : r0 + CW'(1);
        end else begin
          col_nxt = c0 + CW'(1);
          row_nxt = r0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      lc_r  <= '0;
      ctl_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      lc_r  <= lc_nxt;
      if (adv) begin
        ctl_r.vld  <= acc;
        ctl_r.load <= (func == frm_pkg::FUNC_LOAD);
        ctl_r.last <= last;
        ctl_r.mode <= mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      sr_r  <= sr;
      sc_r  <= sc;
      wa_r  <= lc_base[AW-1:0];
      pix_r <= pix;
    end
  end

  assign ctl_a = ctl_r;
  assign sr_a  = sr_r;
  assign sc_a  = sc_r;
  assign wa_a  = wa_r;
  assign pix_a = pix_r;
  assign w_eff = wv;

endmodule

/* design/frm_xform.sv */
module frm_xform (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  frm_pkg::ctl_t ctl,
  input  logic [23:0]   rdata,
  output logic          out_valid,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic          out_single,
  output logic          out_last
);

  logic        valid_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic        single_r, last_r;
  logic [7:0]  r, g, b, red_nxt, green_nxt, blue_nxt;
  logic        single_nxt;
  logic [24:0] gsum;
  logic        emit;

  assign r = rdata[23:16];
  assign g = rdata[15:8];
  assign b = rdata[7:0];
  assign emit = ctl.vld && !ctl.load;

  assign gsum = 25'(frm_pkg::GRAY_R_COEF) * 25'(r)
              + 25'(frm_pkg::GRAY_G_COEF) * 25'(g)
              + 25'(frm_pkg::GRAY_B_COEF) * 25'(b);

  always_comb begin
    red_nxt    = r;
    green_nxt  = g;
    blue_nxt   = b;
    single_nxt = 1'b0;
    case (ctl.mode)
      frm_pkg::MODE_GRAY: begin
        red_nxt    = gsum[23:16];
        green_nxt  = '0;
        blue_nxt   = '0;
        single_nxt = 1'b1;
      end
      frm_pkg::MODE_NEGATIVE: begin
        red_nxt   = frm_pkg::PIX_MAX - r;
        green_nxt = frm_pkg::PIX_MAX - g;
        blue_nxt  = frm_pkg::PIX_MAX - b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
      single_r <= single_nxt;
      last_r   <= ctl.last;
    end
  end

  assign out_valid  = valid_r;
  assign out_red    = red_r;
  assign out_green  = green_r;
  assign out_blue   = blue_r;
  assign out_single = single_r;
  assign out_last   = last_r;

endmodule

/* design/frame_rotate_mirror_engine_top.sv */
// channel  handshake          payload
// in       in_valid/in_stall  in_func, in_red, in_green, in_blue
// out      out_valid/out_stall out_red, out_green, out_blue,
//                             out_single_channel, out_frame_last
// cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; an emit result is
// registered through the scan stage, frame store read and pixel transform register.
// The single frame store port takes either the load write or the emit read.
// A stalled result holds the whole pipeline, loads included.
// Synchronous active-low reset; frame store has no clearing pass.
module frame_rotate_mirror_engine_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_single_channel,
  output logic       out_frame_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW    = $clog2(MAXD + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LCW   = $clog2(DEPTH + 1);
  localparam int PW    = 2 * CW;

  frm_pkg::mode_t mode_r;
  logic [8:0]     fw_r, fh_r;

  logic           adv, acc;
  frm_pkg::ctl_t  ctl_a, ctl_b_r;
  logic [CW-1:0]  sr_a, sc_a, w_eff;
  logic [AW-1:0]  wa_a, ram_addr;
  logic [23:0]    pix_a, ram_rdata;
  logic [PW-1:0]  rd_lin;
  logic           ram_we, ram_re;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= frm_pkg::MODE_COPY;
      fw_r   <= frm_pkg::DIM_RESET;
      fh_r   <= frm_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        frm_pkg::CFG_MODE:   mode_r <= frm_pkg::mode_t'(cfg_data[2:0]);
        frm_pkg::CFG_WIDTH:  fw_r   <= cfg_data;
        frm_pkg::CFG_HEIGHT: fh_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  frm_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CW        (CW),
    .AW        (AW),
    .LCW       (LCW)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .acc  (acc),
    .func (in_func),
    .pix  ({in_red, in_green, in_blue}),
    .mode (mode_r),
    .fw   (fw_r),
    .fh   (fh_r),
    .ctl_a(ctl_a),
    .sr_a (sr_a),
    .sc_a (sc_a),
    .wa_a (wa_a),
    .pix_a(pix_a),
    .w_eff(w_eff)
  );

  assign rd_lin   = PW'(sr_a) * PW'(w_eff) + PW'(sc_a);
  assign ram_we   = adv && ctl_a.vld && ctl_a.load;
  assign ram_re   = adv && ctl_a.vld && !ctl_a.load;
  assign ram_addr = ctl_a.load ? wa_a : rd_lin[AW-1:0];

  frm_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .addr (ram_addr),
    .we   (ram_we),
    .wdata(pix_a),
    .re   (ram_re),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (adv) begin
      ctl_b_r <= ctl_a;
    end
  end

  frm_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl       (ctl_b_r),
    .rdata     (ram_rdata),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_single(out_single_channel),
    .out_last  (out_frame_last)
  );

`ifndef ASSERT_OFF
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("frame store written and read in one cycle");

  a_hold_b: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(ctl_b_r))
    else $error("read stage moved while output stalled");

  a_gray_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_single_channel |-> out_green == '0 && out_blue == '0)
    else $error("gray item carries color bytes");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> ctl_b_r.vld && !ctl_b_r.load)
    else $error("frame store read without emit item behind it");
`endif

endmodule
